@@ hw/rtl/nmtq_pkg.sv @@
// nmtq_pkg: shared types, constants and codes of the note transmit queue
// depends on nothing; used by the front, command queue, back and top modules
package nmtq_pkg;

  // default sizes
  localparam int unsigned FIFO_DEPTH_DEF    = 64;
  localparam int unsigned CHANNEL_COUNT_DEF = 4;
  localparam int unsigned CMD_QUEUE_DEPTH   = 2;

  // midi codes
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_BEND     = 4'hE;
  localparam logic [7:0] VEL_ON       = 8'h40;
  localparam logic [7:0] VEL_OFF      = 8'h00;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] PROG_SILENT  = 8'h7F;
  localparam logic [7:0] PROG_UNKNOWN = 8'd128;
  localparam logic [7:0] BEND_CENTER  = 8'd64;
  localparam logic [7:0] BEND_LIMIT   = 8'd200;
  localparam logic [7:0] DATA_MAX     = 8'd127;
  // 1/25 in 17 fraction bits, for x*64/200 = x*8/25
  localparam logic [12:0] RECIP_25    = 13'd5243;

  // reset values of the reserve registers
  localparam logic [7:0] ON_RESERVE_RST  = 8'd8;
  localparam logic [7:0] OFF_RESERVE_RST = 8'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_NOTE_ON_RESERVE  = 2'd0,
    REG_NOTE_OFF_RESERVE = 2'd1
  } reg_idx_e;

  // input opcodes
  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_NOTE_ON   = 4'd1,
    OP_LAYERED   = 4'd2,
    OP_NOTE_OFF  = 4'd3,
    OP_PROGRAM   = 4'd4,
    OP_FORCEPROG = 4'd5,
    OP_BEND      = 4'd6,
    OP_SILENCE   = 4'd7,
    OP_PANIC     = 4'd8
  } op_e;

  // classified command kind
  typedef enum logic [3:0] {
    K_NONE,
    K_TICK,
    K_ON,
    K_LAYER,
    K_OFF,
    K_PROG,
    K_FORCE,
    K_BEND,
    K_SIL,
    K_PANIC
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       chok;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] prog;
    logic       bend_neg;
    logic [6:0] bend_mag;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [7:0]  free_slots;
    logic [7:0]  peak_fill;
    logic [15:0] lost_note_ons;
    logic [15:0] lost_note_offs;
    logic        note_is_sounding;
    logic [7:0]  channel_voices;
    logic [7:0]  channel_program;
  } res_t;

endpackage

@@ hw/rtl/nmtq_ram.sv @@
// nmtq_ram: generic single write port ram with registered read
// depends on nothing
module nmtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/nmtq_front.sv @@
// nmtq_front: decodes an incoming item into a command and scales the bend
// depends on nmtq_pkg
module nmtq_front #(
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic               [3:0]  opcode_i,
  input  logic               [3:0]  channel_i,
  input  logic               [7:0]  note_number_i,
  input  logic               [7:0]  program_number_i,
  input  logic signed        [15:0] bend_cents_i,
  output nmtq_pkg::cmd_t            cmd_o
);
  import nmtq_pkg::*;

  logic        chok;
  logic [7:0]  mag;
  logic [10:0] mag_x8;
  logic [23:0] prod;

  assign chok = ({1'b0, channel_i} < 5'(CHANNEL_COUNT));

  // clamp to the bend range and take the magnitude
  always_comb begin
    if (bend_cents_i > 16'sd200) begin
      mag = BEND_LIMIT;
    end else if (bend_cents_i < -16'sd200) begin
      mag = BEND_LIMIT;
    end else if (bend_cents_i < 16'sd0) begin
      mag = 8'(-bend_cents_i);
    end else begin
      mag = 8'(bend_cents_i);
    end
  end

  // mag*64/200 by reciprocal, exact for mag up to 200
  assign mag_x8 = {mag, 3'b000};
  assign prod   = 24'(mag_x8) * 24'(RECIP_25);

  // classify opcode
  always_comb begin
    cmd_o.chok     = chok;
    cmd_o.channel  = channel_i;
    cmd_o.note     = note_number_i[6:0];
    cmd_o.prog     = program_number_i[6:0];
    cmd_o.bend_neg = bend_cents_i[15];
    cmd_o.bend_mag = prod[23:17];
    unique case (opcode_i)
      OP_TICK:      cmd_o.kind = K_TICK;
      OP_PANIC:     cmd_o.kind = K_PANIC;
      OP_NOTE_ON:   cmd_o.kind = chok ? K_ON    : K_NONE;
      OP_LAYERED:   cmd_o.kind = chok ? K_LAYER : K_NONE;
      OP_NOTE_OFF:  cmd_o.kind = chok ? K_OFF   : K_NONE;
      OP_PROGRAM:   cmd_o.kind = chok ? K_PROG  : K_NONE;
      OP_FORCEPROG: cmd_o.kind = chok ? K_FORCE : K_NONE;
      OP_BEND:      cmd_o.kind = chok ? K_BEND  : K_NONE;
      OP_SILENCE:   cmd_o.kind = chok ? K_SIL   : K_NONE;
      default:      cmd_o.kind = K_NONE;
    endcase
  end

endmodule

@@ hw/rtl/nmtq_cmd_queue.sv @@
// nmtq_cmd_queue: short command queue between front and back
// depends on nmtq_pkg
module nmtq_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nmtq_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nmtq_pkg::cmd_t data_o
);
  import nmtq_pkg::*;

  localparam int unsigned PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t            entry_q [CMD_QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CNTW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNTW'(CMD_QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rptr_q];

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/nmtq_back.sv @@
// nmtq_back: carries out commands: byte fifo, running status, note maps
// depends on nmtq_pkg and nmtq_ram
module nmtq_back #(
  parameter int unsigned FIFO_DEPTH    = 64,
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  nmtq_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic [7:0]     on_reserve_i,
  input  logic [7:0]     off_reserve_i,
  output logic           done_o,
  output nmtq_pkg::res_t res_o
);
  import nmtq_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned KW = $clog2(CHANNEL_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_TICK, S_PUSH, S_SIL, S_PANIC, S_DONE
  } state_e;

  state_e        state_q, ret_q;
  cmd_t          cmd_q;
  logic [AW-1:0] wr_q, rd_q;
  logic [7:0]    last_q;
  logic [127:0]  bmp_q   [CHANNEL_COUNT];
  logic [7:0]    voice_q [CHANNEL_COUNT];
  logic [7:0]    prog_q  [CHANNEL_COUNT];
  logic [7:0]    peak_q;
  logic [15:0]   on_drop_q, off_drop_q;
  logic [7:0]    bytes_q [5];
  logic [2:0]    cnt_q;
  logic [7:0]    n_q;
  logic [KW-1:0] k_q;
  logic          acc_q, txv_q, sample_q;
  logic [7:0]    txb_q;
  res_t          res_q;
  logic          done_q;

  logic [AW:0]   fill, free;
  logic [AW-1:0] wr_nxt, rd_nxt;
  logic          full, low_on, low_off;
  logic [CW-1:0] chi;
  logic          cur_on, sil_on, prog_do;
  logic [7:0]    st_on, st_bend, msb_raw, msb;
  logic [7:0]    lst [5];
  logic [2:0]    lcnt;
  logic [7:0]    peak_new;
  logic [7:0]    ram_rdata;
  logic          ram_we;

  // fifo level
  always_comb begin
    if (wr_q >= rd_q) begin
      fill = {1'b0, wr_q} - {1'b0, rd_q};
    end else begin
      fill = {1'b0, wr_q} + (AW+1)'(FIFO_DEPTH) - {1'b0, rd_q};
    end
  end
  assign free    = (AW+1)'(FIFO_DEPTH - 1) - fill;
  assign wr_nxt  = (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign rd_nxt  = (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign full    = (wr_nxt == rd_q);
  assign low_on  = (9'(free) < {1'b0, on_reserve_i});
  assign low_off = (9'(free) < {1'b0, off_reserve_i});

  // addressed channel
  assign chi     = cmd_q.channel[CW-1:0];
  assign cur_on  = bmp_q[chi][cmd_q.note];
  assign sil_on  = bmp_q[chi][n_q[6:0]];
  assign prog_do = (cmd_q.kind == K_FORCE) || (prog_q[chi] != {1'b0, cmd_q.prog});
  assign st_on   = {NIB_NOTE_ON, cmd_q.channel};
  assign st_bend = {NIB_BEND, cmd_q.channel};

  // bend data byte
  assign msb_raw = cmd_q.bend_neg ? BEND_CENTER - {1'b0, cmd_q.bend_mag}
                                  : BEND_CENTER + {1'b0, cmd_q.bend_mag};
  assign msb     = (msb_raw > DATA_MAX) ? DATA_MAX : msb_raw;

  // byte list for the next burst of pushes
  always_comb begin
    logic [2:0] i;
    i = '0;
    for (int j = 0; j < 5; j++) begin
      lst[j] = BYTE_ZERO;
    end
    case (state_q)
      S_DEC: begin
        case (cmd_q.kind)
          K_ON, K_LAYER: begin
            if (st_on != last_q) begin
              lst[i] = st_on;
              i = i + 1'b1;
            end
            if (cmd_q.kind == K_ON && cur_on) begin
              lst[i] = {1'b0, cmd_q.note};
              lst[i+1] = VEL_OFF;
              i = i + 3'd2;
            end
            lst[i] = {1'b0, cmd_q.note};
            lst[i+1] = VEL_ON;
            i = i + 3'd2;
          end
          K_OFF: begin
            if (st_on != last_q) begin
              lst[i] = st_on;
              i = i + 1'b1;
            end
            lst[i] = {1'b0, cmd_q.note};
            lst[i+1] = VEL_OFF;
            i = i + 3'd2;
          end
          K_PROG, K_FORCE: begin
            lst[0] = {NIB_PROGRAM, cmd_q.channel};
            lst[1] = {1'b0, cmd_q.prog};
            i = 3'd2;
          end
          K_BEND: begin
            if (st_bend != last_q) begin
              lst[i] = st_bend;
              i = i + 1'b1;
            end
            lst[i] = BYTE_ZERO;
            lst[i+1] = msb;
            i = i + 3'd2;
          end
          default: i = '0;
        endcase
      end
      S_SIL: begin
        if (st_on != last_q) begin
          lst[i] = st_on;
          i = i + 1'b1;
        end
        lst[i] = {1'b0, n_q[6:0]};
        lst[i+1] = VEL_OFF;
        i = i + 3'd2;
      end
      S_PANIC: begin
        lst[0] = {NIB_PROGRAM, 4'(k_q)};
        lst[1] = PROG_SILENT;
        i = 3'd2;
      end
      default: i = '0;
    endcase
    lcnt = i;
  end

  // byte fifo storage
  assign ram_we = (state_q == S_PUSH) && !full;

  nmtq_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (bytes_q[0]),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  assign peak_new  = (sample_q && (8'(fill) > peak_q)) ? 8'(fill) : peak_q;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign done_o    = done_q;
  assign res_o     = res_q;

  // sequencer, command payload and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_DONE;
      wr_q       <= '0;
      rd_q       <= '0;
      last_q     <= '0;
      peak_q     <= '0;
      on_drop_q  <= '0;
      off_drop_q <= '0;
      cnt_q      <= '0;
      n_q        <= '0;
      k_q        <= '0;
      acc_q      <= 1'b0;
      txv_q      <= 1'b0;
      txb_q      <= '0;
      sample_q   <= 1'b0;
      done_q     <= 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        bmp_q[c]   <= '0;
        voice_q[c] <= '0;
        prog_q[c]  <= PROG_UNKNOWN;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            acc_q    <= 1'b0;
            txv_q    <= 1'b0;
            txb_q    <= '0;
            sample_q <= 1'b0;
            n_q      <= '0;
            k_q      <= '0;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          bytes_q <= lst;
          cnt_q   <= lcnt;
          ret_q   <= S_DONE;
          state_q <= S_DONE;
          case (cmd_q.kind)
            K_TICK: begin
              if (rd_q != wr_q) begin
                state_q <= S_TICK;
              end
            end
            K_ON, K_LAYER: begin
              if (low_on) begin
                on_drop_q <= on_drop_q + 1'b1;
              end else begin
                last_q                <= st_on;
                bmp_q[chi][cmd_q.note] <= 1'b1;
                if (!cur_on) begin
                  voice_q[chi] <= voice_q[chi] + 1'b1;
                end
                acc_q    <= 1'b1;
                sample_q <= 1'b1;
                state_q  <= S_PUSH;
              end
            end
            K_OFF: begin
              if (!cur_on) begin
                acc_q <= 1'b1;
              end else if (low_off) begin
                off_drop_q <= off_drop_q + 1'b1;
              end else begin
                last_q                <= st_on;
                bmp_q[chi][cmd_q.note] <= 1'b0;
                voice_q[chi]          <= voice_q[chi] - 1'b1;
                acc_q    <= 1'b1;
                sample_q <= 1'b1;
                state_q  <= S_PUSH;
              end
            end
            K_PROG, K_FORCE: begin
              if (!prog_do) begin
                acc_q <= 1'b1;
              end else if (!low_on) begin
                last_q       <= '0;
                bmp_q[chi]   <= '0;
                voice_q[chi] <= '0;
                prog_q[chi]  <= ({1'b0, cmd_q.prog} == PROG_SILENT) ? PROG_UNKNOWN
                                                                    : {1'b0, cmd_q.prog};
                acc_q    <= 1'b1;
                sample_q <= 1'b1;
                state_q  <= S_PUSH;
              end
            end
            K_BEND: begin
              if (!low_on) begin
                last_q   <= st_bend;
                acc_q    <= 1'b1;
                sample_q <= 1'b1;
                state_q  <= S_PUSH;
              end
            end
            K_SIL:   state_q <= S_SIL;
            K_PANIC: state_q <= S_PANIC;
            default: state_q <= S_DONE;
          endcase
        end
        S_TICK: begin
          txb_q   <= ram_rdata;
          txv_q   <= 1'b1;
          acc_q   <= 1'b1;
          rd_q    <= rd_nxt;
          state_q <= S_DONE;
        end
        S_PUSH: begin
          for (int j = 0; j < 4; j++) begin
            bytes_q[j] <= bytes_q[j+1];
          end
          if (!full) begin
            wr_q <= wr_nxt;
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 3'd1) begin
            state_q <= ret_q;
          end
        end
        S_SIL: begin
          if (n_q[7]) begin
            acc_q    <= 1'b1;
            sample_q <= 1'b1;
            state_q  <= S_DONE;
          end else if (sil_on && low_off) begin
            off_drop_q <= off_drop_q + 1'b1;
            state_q    <= S_DONE;
          end else if (sil_on) begin
            bytes_q               <= lst;
            cnt_q                 <= lcnt;
            last_q                <= st_on;
            bmp_q[chi][n_q[6:0]]  <= 1'b0;
            voice_q[chi]          <= voice_q[chi] - 1'b1;
            n_q                   <= n_q + 1'b1;
            ret_q                 <= S_SIL;
            state_q               <= S_PUSH;
          end else begin
            n_q <= n_q + 1'b1;
          end
        end
        S_PANIC: begin
          if (k_q == KW'(CHANNEL_COUNT)) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
              bmp_q[c]   <= '0;
              voice_q[c] <= '0;
              prog_q[c]  <= PROG_UNKNOWN;
            end
            last_q   <= '0;
            acc_q    <= 1'b1;
            sample_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            bytes_q <= lst;
            cnt_q   <= lcnt;
            k_q     <= k_q + 1'b1;
            ret_q   <= S_PANIC;
            state_q <= S_PUSH;
          end
        end
        S_DONE: begin
          peak_q                 <= peak_new;
          res_q.accepted         <= acc_q;
          res_q.tx_valid         <= txv_q;
          res_q.tx_byte          <= txb_q;
          res_q.free_slots       <= 8'(free);
          res_q.peak_fill        <= peak_new;
          res_q.lost_note_ons    <= on_drop_q;
          res_q.lost_note_offs   <= off_drop_q;
          res_q.note_is_sounding <= cmd_q.chok ? cur_on : 1'b0;
          res_q.channel_voices   <= cmd_q.chok ? voice_q[chi] : 8'd0;
          res_q.channel_program  <= cmd_q.chok ? prog_q[chi] : PROG_UNKNOWN;
          done_q                 <= 1'b1;
          state_q                <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/midi_note_tx_queue_unit.sv @@
// midi_note_tx_queue_unit: top level of the running status note transmitter
// depends on nmtq_pkg, nmtq_front, nmtq_cmd_queue, nmtq_back, nmtq_ram
//
//  channel   direction  handshake              payload
//  command   in         start_i, busy_o        opcode, channel, note, program, bend
//  config    in         cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//  result    out        done_o (one cycle)     accepted .. channel_program
//
// with the back part free, an item passes from accept through the command queue
// and back sequencer to its result; a tick that sends a byte adds a fifo read,
// note, program and bend a push per byte, silence a scan of all 128 notes with
// pushes for each released note, panic a program change per channel. the fifo
// takes one byte per cycle; the scan checks one note per cycle, save while pushing.
// two commands queue between front and back; busy_o rises when that is full.
// reset clears the note maps, program caches, counters and fifo pointers.
// results cannot be stalled; each one shows for one cycle on done_o.
module midi_note_tx_queue_unit #(
  parameter int unsigned FIFO_DEPTH    = nmtq_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned CHANNEL_COUNT = nmtq_pkg::CHANNEL_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         opcode_i,
  input  logic [3:0]         channel_i,
  input  logic [7:0]         note_number_i,
  input  logic [7:0]         program_number_i,
  input  logic signed [15:0] bend_cents_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output logic               done_o,
  output logic               accepted_o,
  output logic               tx_valid_o,
  output logic [7:0]         tx_byte_o,
  output logic [7:0]         free_slots_o,
  output logic [7:0]         peak_fill_o,
  output logic [15:0]        lost_note_ons_o,
  output logic [15:0]        lost_note_offs_o,
  output logic               note_is_sounding_o,
  output logic [7:0]         channel_voices_o,
  output logic [7:0]         channel_program_o
);
  import nmtq_pkg::*;

  cmd_t       front_cmd, q_cmd;
  logic       q_full, q_valid, q_pop, item_ok;
  logic [7:0] on_res_q, off_res_q;
  res_t       res;

  assign busy_o      = q_full;
  assign item_ok     = start_i && !q_full;
  assign cfg_ready_o = 1'b1;

  // reserve registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_res_q  <= ON_RESERVE_RST;
      off_res_q <= OFF_RESERVE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NOTE_ON_RESERVE:  on_res_q  <= cfg_data_i;
        REG_NOTE_OFF_RESERVE: off_res_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nmtq_front #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .opcode_i         (opcode_i),
    .channel_i        (channel_i),
    .note_number_i    (note_number_i),
    .program_number_i (program_number_i),
    .bend_cents_i     (bend_cents_i),
    .cmd_o            (front_cmd)
  );

  nmtq_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_ok),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  nmtq_back #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .on_reserve_i  (on_res_q),
    .off_reserve_i (off_res_q),
    .done_o        (done_o),
    .res_o         (res)
  );

  // result fields
  assign accepted_o         = res.accepted;
  assign tx_valid_o         = res.tx_valid;
  assign tx_byte_o          = res.tx_byte;
  assign free_slots_o       = res.free_slots;
  assign peak_fill_o        = res.peak_fill;
  assign lost_note_ons_o    = res.lost_note_ons;
  assign lost_note_offs_o   = res.lost_note_offs;
  assign note_is_sounding_o = res.note_is_sounding;
  assign channel_voices_o   = res.channel_voices;
  assign channel_program_o  = res.channel_program;

endmodule

@@ hw/rtl/nmtq_checker.sv @@
// nmtq_checker: port level checks of the note transmitter, bound to the top
// depends on midi_note_tx_queue_unit
module nmtq_checker #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       done_o,
  input logic       accepted_o,
  input logic       tx_valid_o,
  input logic [7:0] free_slots_o,
  input logic [7:0] peak_fill_o,
  input logic [7:0] channel_voices_o,
  input logic [7:0] channel_program_o
);

  logic [7:0] peak_seen_q;

  // last reported peak
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_seen_q <= '0;
    end else if (done_o) begin
      peak_seen_q <= peak_fill_o;
    end
  end

  // a sent byte always counts as an accepted tick
  a_tx_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && tx_valid_o) |-> accepted_o) else $error("tx without accept");

  // the peak never falls and free space stays inside the fifo
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (peak_fill_o >= peak_seen_q) &&
               ({24'd0, free_slots_o} <= FIFO_DEPTH - 1)) else $error("fifo level");

  // channel query stays in range
  a_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (channel_program_o <= 8'd128) && (channel_voices_o <= 8'd128))
    else $error("channel query range");

  // a result is never followed directly by another
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("results back to back");

endmodule

bind midi_note_tx_queue_unit nmtq_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_nmtq_checker (.*);
